// ----- hdl/radial_stick_deadzone_unit_macros.svh -----
// Assertion shorthands used by the FIFO RTL file.
`ifndef RADIAL_STICK_DEADZONE_UNIT_MACROS_SVH
`define RADIAL_STICK_DEADZONE_UNIT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define RSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define RSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rsd_pkg.sv -----
package rsd_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned DEAD_W    = 15;
  localparam int unsigned SUMSQ_W   = 2 * AXIS_W;
  localparam int unsigned MAG_W     = AXIS_W + FRAC_BITS;
  localparam int unsigned RAD_W     = 2 * MAG_W;
  localparam int unsigned REM_W     = MAG_W + 2;
  localparam int unsigned LEN_W     = DEAD_W + FRAC_BITS;
  localparam int unsigned ABS_W     = AXIS_W + 1;
  localparam int unsigned PROD_W    = ABS_W + LEN_W;
  localparam int unsigned SCALE_W   = PROD_W + 7;
  localparam int unsigned DEN_W     = MAG_W + DEAD_W + 1;
  localparam int unsigned DIV_W     = SCALE_W + 2;
  localparam int unsigned Q_W       = 9;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [DEAD_W-1:0] MAX_MAG  = '1;
  localparam logic [MAG_W-1:0]  CLAMP_FX = {{(MAG_W-DEAD_W-FRAC_BITS){1'b0}}, MAX_MAG,
                                            {FRAC_BITS{1'b0}}};
  localparam logic [7:0]        CENTER   = 8'd128;

  typedef struct packed {
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
  } stick_t;

  typedef struct packed {
    logic [7:0] byte_x;
    logic [7:0] byte_y;
  } byte_t;

  // word handed from the classify/root front to the scaling back
  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic                     centre;
    logic [MAG_W-1:0]         mag;
  } mid_t;

endpackage

// ----- hdl/rsd_front.sv -----
module rsd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rsd_pkg::DEAD_W-1:0] dead_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rsd_pkg::stick_t            in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rsd_pkg::mid_t              out_data_o
);

  localparam int unsigned MW = rsd_pkg::MAG_W;

  typedef struct packed {
    logic signed [rsd_pkg::AXIS_W-1:0] x;
    logic signed [rsd_pkg::AXIS_W-1:0] y;
    logic                              centre;
    logic [MW-1:0]                     res;
    logic [rsd_pkg::REM_W-1:0]         rem;
    logic [rsd_pkg::RAD_W-1:0]         rad;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t                       o;
    logic [rsd_pkg::REM_W-1:0] cur;
    logic [rsd_pkg::REM_W-1:0] trial;
    o     = s;
    cur   = {s.rem[rsd_pkg::REM_W-3:0], s.rad[rsd_pkg::RAD_W-1 -: 2]};
    trial = {s.res, 2'b01};
    o.rad = {s.rad[rsd_pkg::RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem = cur - trial;
      o.res = {s.res[MW-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.res = {s.res[MW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [2*rsd_pkg::DEAD_W-1:0]  dead_sq_q;
  logic                          dead_max_q;
  logic                          a_vld_q;
  logic signed [rsd_pkg::AXIS_W-1:0] a_x_q, a_y_q;
  logic [rsd_pkg::SUMSQ_W-2:0]   a_xx_q, a_yy_q;
  logic signed [rsd_pkg::SUMSQ_W-1:0] xx_w, yy_w;
  logic [rsd_pkg::SUMSQ_W-1:0]   sum_w;
  sq_t                           sq_q [0:MW];
  logic [MW:0]                   sv_q;
  logic                          en;

  assign en         = !sv_q[MW] || out_ready_i;
  assign in_ready_o = en;
  assign xx_w       = rsd_pkg::SUMSQ_W'(in_data_i.stick_x) * rsd_pkg::SUMSQ_W'(in_data_i.stick_x);
  assign yy_w       = rsd_pkg::SUMSQ_W'(in_data_i.stick_y) * rsd_pkg::SUMSQ_W'(in_data_i.stick_y);
  assign sum_w      = {1'b0, a_xx_q} + {1'b0, a_yy_q};

  always_ff @(posedge clk_i) begin
    dead_sq_q  <= (2*rsd_pkg::DEAD_W)'(dead_i) * (2*rsd_pkg::DEAD_W)'(dead_i);
    dead_max_q <= (dead_i == rsd_pkg::MAX_MAG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      sv_q    <= '0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      sv_q    <= {sv_q[MW-1:0], a_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q            <= in_data_i.stick_x;
      a_y_q            <= in_data_i.stick_y;
      a_xx_q           <= xx_w[rsd_pkg::SUMSQ_W-2:0];
      a_yy_q           <= yy_w[rsd_pkg::SUMSQ_W-2:0];
      sq_q[0].x        <= a_x_q;
      sq_q[0].y        <= a_y_q;
      sq_q[0].centre   <= (sum_w <= {2'b00, dead_sq_q}) || dead_max_q;
      sq_q[0].res      <= '0;
      sq_q[0].rem      <= '0;
      sq_q[0].rad      <= {sum_w, {(2*rsd_pkg::FRAC_BITS){1'b0}}};
      // one root bit per stage
      for (int k = 0; k < MW; k++) begin
        sq_q[k+1] <= sq_step(sq_q[k]);
      end
    end
  end

  assign out_valid_o       = sv_q[MW];
  assign out_data_o.x      = sq_q[MW].x;
  assign out_data_o.y      = sq_q[MW].y;
  assign out_data_o.centre = sq_q[MW].centre;
  assign out_data_o.mag    = sq_q[MW].res;

endmodule

// ----- hdl/rsd_fifo.sv -----
`include "radial_stick_deadzone_unit_macros.svh"

module rsd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsd_pkg::mid_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsd_pkg::mid_t out_data_o
);

  rsd_pkg::mid_t                 mem_q [0:rsd_pkg::FIFO_DEPTH-1];
  logic [rsd_pkg::FIFO_AW-1:0]   wr_q, rd_q;
  logic [rsd_pkg::FIFO_AW:0]     cnt_q;
  logic                          push, pop;

  assign in_ready_o  = (cnt_q != (rsd_pkg::FIFO_AW+1)'(rsd_pkg::FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + rsd_pkg::FIFO_AW'(1);
      if (pop)  rd_q <= rd_q + rsd_pkg::FIFO_AW'(1);
      if (push && !pop) cnt_q <= cnt_q + (rsd_pkg::FIFO_AW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (rsd_pkg::FIFO_AW+1)'(1);
    end
  end

  `RSD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (rsd_pkg::FIFO_AW+1)'(rsd_pkg::FIFO_DEPTH), "fifo over depth")
  `RSD_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "fifo count lost a push")
  `RSD_ASSERT_NEXT(a_cnt_dn, clk_i, rst_ni, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "fifo count lost a pop")
  `RSD_ASSERT_NEXT(a_ptr_gap, clk_i, rst_ni, 1'b1, wr_q == rd_q + cnt_q[rsd_pkg::FIFO_AW-1:0], "fifo pointers disagree with count")

endmodule

// ----- hdl/rsd_back.sv -----
module rsd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rsd_pkg::DEAD_W-1:0] dead_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rsd_pkg::mid_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rsd_pkg::byte_t             out_data_o
);

  localparam int unsigned LAST = rsd_pkg::Q_W + 5;
  localparam int unsigned DW   = rsd_pkg::DIV_W;

  typedef struct packed {
    logic                      centre;
    logic                      xneg;
    logic                      yneg;
    logic [DW-1:0]             remx;
    logic [DW-1:0]             remy;
    logic [rsd_pkg::DEN_W-1:0] den;
    logic [rsd_pkg::Q_W-1:0]   qx;
    logic [rsd_pkg::Q_W-1:0]   qy;
  } div_t;

  function automatic div_t div_step(div_t s, logic [3:0] b);
    div_t          o;
    logic [DW-1:0] dsh;
    o   = s;
    dsh = DW'(s.den) << b;
    if (s.remx >= dsh) begin
      o.remx  = s.remx - dsh;
      o.qx[b] = 1'b1;
    end
    if (s.remy >= dsh) begin
      o.remy  = s.remy - dsh;
      o.qy[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [7:0] to_byte(logic neg, logic [rsd_pkg::Q_W-1:0] q);
    logic signed [rsd_pkg::Q_W+1:0] v;
    v = neg ? $signed({2'b00, 1'b0, rsd_pkg::CENTER}) - $signed({2'b00, q})
            : $signed({2'b00, 1'b0, rsd_pkg::CENTER}) + $signed({2'b00, q});
    if (v < 0)             return 8'd0;
    else if (v > 255)      return 8'd255;
    else                   return v[7:0];
  endfunction

  logic [LAST:0]                  vld_q;
  logic                           en;
  rsd_pkg::mid_t                  p0_q;
  // stage 1
  logic                           p1_centre_q, p1_xneg_q, p1_yneg_q;
  logic [rsd_pkg::ABS_W-1:0]      p1_ax_q, p1_ay_q;
  logic [rsd_pkg::LEN_W-1:0]      p1_len_q;
  logic [rsd_pkg::DEAD_W-1:0]     p1_span_q;
  logic [rsd_pkg::MAG_W-1:0]      p1_mag_q;
  // stage 2
  logic                           p2_centre_q, p2_xneg_q, p2_yneg_q;
  logic [rsd_pkg::PROD_W-1:0]     p2_px_q, p2_py_q;
  logic [rsd_pkg::DEN_W-2:0]      p2_d_q;
  // stage 3
  logic                           p3_centre_q, p3_xneg_q, p3_yneg_q;
  logic [rsd_pkg::SCALE_W-1:0]    p3_nx_q, p3_ny_q;
  logic [rsd_pkg::DEN_W-2:0]      p3_d_q;
  div_t                           dv_q [0:rsd_pkg::Q_W];
  rsd_pkg::byte_t                 out_q;

  logic [rsd_pkg::MAG_W-1:0]      clp_w, dead_fx_w;
  logic [rsd_pkg::LEN_W-1:0]      len_w;
  logic [rsd_pkg::ABS_W-1:0]      xe_w, ye_w;

  assign en         = !vld_q[LAST] || out_ready_i;
  assign in_ready_o = en;

  assign clp_w     = (p0_q.mag < rsd_pkg::CLAMP_FX) ? p0_q.mag : rsd_pkg::CLAMP_FX;
  assign dead_fx_w = rsd_pkg::MAG_W'({dead_i, {rsd_pkg::FRAC_BITS{1'b0}}});
  assign len_w     = (clp_w > dead_fx_w) ? rsd_pkg::LEN_W'(clp_w - dead_fx_w) : '0;
  assign xe_w      = {p0_q.x[rsd_pkg::AXIS_W-1], p0_q.x};
  assign ye_w      = {p0_q.y[rsd_pkg::AXIS_W-1], p0_q.y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= in_data_i;

      p1_centre_q <= p0_q.centre || (len_w == '0) || (p0_q.mag == '0);
      p1_xneg_q   <= p0_q.x[rsd_pkg::AXIS_W-1];
      p1_yneg_q   <= p0_q.y[rsd_pkg::AXIS_W-1];
      p1_ax_q     <= xe_w[rsd_pkg::ABS_W-1] ? (~xe_w + rsd_pkg::ABS_W'(1)) : xe_w;
      p1_ay_q     <= ye_w[rsd_pkg::ABS_W-1] ? (~ye_w + rsd_pkg::ABS_W'(1)) : ye_w;
      p1_len_q    <= len_w;
      p1_span_q   <= rsd_pkg::MAX_MAG - dead_i;
      p1_mag_q    <= p0_q.mag;

      p2_centre_q <= p1_centre_q;
      p2_xneg_q   <= p1_xneg_q;
      p2_yneg_q   <= p1_yneg_q;
      p2_px_q     <= rsd_pkg::PROD_W'(p1_ax_q) * rsd_pkg::PROD_W'(p1_len_q);
      p2_py_q     <= rsd_pkg::PROD_W'(p1_ay_q) * rsd_pkg::PROD_W'(p1_len_q);
      p2_d_q      <= (rsd_pkg::DEN_W-1)'(p1_mag_q) * (rsd_pkg::DEN_W-1)'(p1_span_q);

      // times 127 as shift and subtract
      p3_centre_q <= p2_centre_q;
      p3_xneg_q   <= p2_xneg_q;
      p3_yneg_q   <= p2_yneg_q;
      p3_nx_q     <= {p2_px_q, 7'd0} - rsd_pkg::SCALE_W'(p2_px_q);
      p3_ny_q     <= {p2_py_q, 7'd0} - rsd_pkg::SCALE_W'(p2_py_q);
      p3_d_q      <= p2_d_q;

      // round half away: (2n + d) / 2d
      dv_q[0].centre <= p3_centre_q;
      dv_q[0].xneg   <= p3_xneg_q;
      dv_q[0].yneg   <= p3_yneg_q;
      dv_q[0].remx   <= {1'b0, p3_nx_q, 1'b0} + DW'(p3_d_q);
      dv_q[0].remy   <= {1'b0, p3_ny_q, 1'b0} + DW'(p3_d_q);
      dv_q[0].den    <= {p3_d_q, 1'b0};
      dv_q[0].qx     <= '0;
      dv_q[0].qy     <= '0;

      // one quotient bit per stage, most significant first
      for (int k = 0; k < rsd_pkg::Q_W; k++) begin
        dv_q[k+1] <= div_step(dv_q[k], 4'(rsd_pkg::Q_W - 1 - k));
      end

      if (dv_q[rsd_pkg::Q_W].centre) begin
        out_q.byte_x <= rsd_pkg::CENTER;
        out_q.byte_y <= rsd_pkg::CENTER;
      end else begin
        out_q.byte_x <= to_byte(dv_q[rsd_pkg::Q_W].xneg, dv_q[rsd_pkg::Q_W].qx);
        out_q.byte_y <= to_byte(dv_q[rsd_pkg::Q_W].yneg, dv_q[rsd_pkg::Q_W].qy);
      end
    end
  end

  assign out_valid_o = vld_q[LAST];
  assign out_data_o  = out_q;

endmodule

// ----- hdl/radial_stick_deadzone_unit.sv -----
// Throughput: one word per cycle unless out_ready_i stalls the output; the root takes one
// bit per stage and the divider one quotient bit per stage, both fully pipelined, with a
// four-word queue between them. Reset: asynchronous, active low; clears all valid bits,
// queue pointers and the dead radius (zero). Payload registers are not reset.
module radial_stick_deadzone_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rsd_pkg::DEAD_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rsd_pkg::stick_t            in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rsd_pkg::byte_t             out_data_o
);

  logic [rsd_pkg::DEAD_W-1:0] dead_q;
  logic                       f_valid, f_ready, q_valid, q_ready;
  rsd_pkg::mid_t              f_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= '0;
    end else if (cfg_we_i) begin
      dead_q <= cfg_wdata_i;
    end
  end

  rsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dead_i      (dead_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  rsd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  rsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dead_i      (dead_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
